@@ rtl/core/snmp_pkg.sv @@
// Package for the SNMP GET responder: codes, tags, structs and MIB tables.
// No dependencies; used by the engine, the top level, the checker and the bench.
package snmp_pkg;

    localparam int COMMUNITY_MAX = 16;
    localparam int MIB_LAST      = 11;
    localparam int MIB_OID_LEN   = 11;
    localparam int MIN_PACKET    = 23;

    localparam logic [1:0] ACT_REQ    = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_SENSOR = 2'd2;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_READY    = 3'd1;
    localparam logic [2:0] ST_DROPPED  = 3'd2;
    localparam logic [2:0] ST_BYTE     = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic [1:0] REG_COMM_LEN   = 2'd0;
    localparam logic [1:0] REG_COMM_FIRST = 2'd1;
    localparam logic [1:0] REG_COMM_LAST  = 2'd2;

    localparam logic [7:0] TAG_SEQ     = 8'h30;
    localparam logic [7:0] TAG_INT     = 8'h02;
    localparam logic [7:0] TAG_OCTETS  = 8'h04;
    localparam logic [7:0] TAG_NULL    = 8'h05;
    localparam logic [7:0] TAG_OID     = 8'h06;
    localparam logic [7:0] PDU_GET     = 8'hA0;
    localparam logic [7:0] PDU_NEXT    = 8'hA1;
    localparam logic [7:0] PDU_RESP    = 8'hA2;
    localparam logic [7:0] NO_SUCH_OBJ = 8'h80;

    typedef struct packed {
        logic [4:0]  len;
        logic [63:0] first;
        logic [63:0] last;
    } t_cfg;

    typedef struct packed {
        logic       done;
        logic       ok;
        logic [7:0] size;
    } t_eng_res;

    function automatic logic [7:0] head_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h02;
            2'd1:    v = 8'h01;
            2'd2:    v = 8'h01;
            default: v = 8'h04;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] mid_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h02;
            3'd1:    v = 8'h01;
            3'd2:    v = 8'h00;
            3'd3:    v = 8'h02;
            3'd4:    v = 8'h01;
            3'd5:    v = 8'h00;
            3'd6:    v = 8'h30;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] mib_oid_byte(input logic [3:0] e, input logic [3:0] k);
        logic [7:0] v;
        case (k)
            4'd0:    v = 8'h2B;
            4'd1:    v = 8'h06;
            4'd2:    v = 8'h01;
            4'd3:    v = 8'h02;
            4'd4:    v = 8'h01;
            4'd5:    v = 8'h63;
            4'd6:    v = 8'h01;
            4'd7:    v = 8'h01;
            4'd8:    v = 8'h01;
            4'd9:    v = {5'd0, e[3:1]} + 8'd1;
            default: v = {7'd0, e[0]} + 8'd1;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] unit_char(input logic hum, input logic [2:0] i);
        logic [7:0] v;
        case (i)
            3'd0:    v = "x";
            3'd1:    v = "0";
            3'd2:    v = ".";
            3'd3:    v = "1";
            3'd4:    v = " ";
            3'd5:    v = hum ? "%" : "*";
            3'd6:    v = hum ? "R" : "C";
            default: v = "H";
        endcase
        return v;
    endfunction

    function automatic logic [2:0] int_len(input logic [31:0] u);
        logic [2:0] n;
        if (u[31:7] == '0 || u[31:7] == '1) begin
            n = 3'd1;
        end else if (u[31:15] == '0 || u[31:15] == '1) begin
            n = 3'd2;
        end else if (u[31:23] == '0 || u[31:23] == '1) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

endpackage

@@ rtl/core/snmp_if.sv @@
// Channel interfaces of the SNMP GET responder: request, result and register write.
// Depends on nothing; instantiated by the environment around the top level.
interface snmp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [7:0]         request_byte;
    logic               request_last;
    logic signed [31:0] temperature;
    logic signed [31:0] humidity;
    modport source (output valid, action, request_byte, request_last, temperature, humidity,
                    input ready);
    modport sink   (input valid, action, request_byte, request_last, temperature, humidity,
                    output ready);
endinterface

interface snmp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] response_length;
    logic [7:0] response_byte;
    logic       response_last;
    modport source (output valid, status, response_length, response_byte, response_last,
                    input ready);
    modport sink   (input valid, status, response_length, response_byte, response_last,
                    output ready);
endinterface

interface snmp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [63:0] wr_data;
    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

@@ rtl/core/snmp_mem.sv @@
// Byte-wide single-port-write, registered-read memory for packet buffers.
// No dependencies.
module snmp_mem #(
    parameter int DEPTH = 129,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_q;
endmodule

@@ rtl/core/snmp_engine.sv @@
// Parse-and-build sequencer: walks the request buffer one byte a cycle and writes the response.
// Depends on snmp_pkg; reads the request memory and writes the response memory.
module snmp_engine #(
    parameter int PACKET_BYTES = 129
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [7:0]         i_count,
    input  snmp_pkg::t_cfg     i_cfg,
    input  logic [31:0]        i_temp,
    input  logic [31:0]        i_hum,
    output logic [9:0]         o_rd_addr,
    input  logic [7:0]         i_rd_data,
    output logic               o_wr_en,
    output logic [7:0]         o_wr_addr,
    output logic [7:0]         o_wr_data,
    output snmp_pkg::t_eng_res o_res
);
    import snmp_pkg::*;

    localparam logic [7:0] PktMax = 8'(PACKET_BYTES);

    typedef enum logic [14:0] {
        S_IDLE  = 15'h0001,
        S_HDR   = 15'h0002,
        S_BIND  = 15'h0004,
        S_BNULL = 15'h0008,
        S_BHDR  = 15'h0010,
        S_LOOK  = 15'h0020,
        S_OID   = 15'h0040,
        S_VAL   = 15'h0080,
        S_NFL   = 15'h0100,
        S_NFC   = 15'h0200,
        S_NFZ   = 15'h0400,
        S_BEND  = 15'h0800,
        S_P1    = 15'h1000,
        S_P2    = 15'h2000,
        S_P3    = 15'h4000
    } t_eng_state;

    t_eng_state r_state, n_state;
    logic [7:0] r_k, n_k;
    logic       r_rin, n_rin;
    logic [4:0] r_cl, n_cl;
    logic [2:0] r_idl, n_idl;
    logic       r_get, n_get;
    logic [9:0] r_b, n_b;
    logic [7:0] r_rem, n_rem;
    logic [7:0] r_blen, n_blen;
    logic [7:0] r_olen, n_olen;
    logic [7:0] r_pos, n_pos;
    logic [7:0] r_bi, n_bi;
    logic [7:0] r_bli, n_bli;
    logic [3:0] r_e, n_e;
    logic       r_done, n_done;
    logic       r_ok, n_ok;
    logic [7:0] r_size, n_size;

    logic [9:0]  n_raddr;
    logic [7:0]  d;
    logic [7:0]  rel, t, pdu, m, vlen, ibyte, vbyte;
    logic [3:0]  cidx, nlen;
    logic [63:0] cword;
    logic [7:0]  cbyte;
    logic [31:0] u;
    logic [2:0]  vn;
    logic [1:0]  sel;
    logic        vstr, eq, lt, hit, fail, put_en, pat_en, ovf;
    logic [7:0]  put_val, pat_addr, pat_val, vi;

    assign d     = r_rin ? i_rd_data : 8'h00;
    assign rel   = r_k - 8'd7 - {3'd0, r_cl};
    assign t     = rel - 8'd4 - {5'd0, r_idl};
    assign pdu   = 8'd8 + {3'd0, r_cl};
    assign cidx  = 4'(r_k - 8'd7);
    assign cword = cidx[3] ? i_cfg.last : i_cfg.first;
    assign cbyte = 8'(cword >> {~cidx[2:0], 3'b000});
    assign nlen  = (r_olen < 8'(MIB_OID_LEN)) ? r_olen[3:0] : 4'(MIB_OID_LEN);
    assign m     = mib_oid_byte(r_e, r_k[3:0]);
    assign vstr  = (r_e[3:1] == 3'd5);
    assign vn    = int_len(u);
    assign vlen  = vstr ? (r_e[0] ? 8'd8 : 8'd7) : {5'd0, vn};
    assign vi    = r_k - 8'd2;
    assign sel   = 2'(vn - 3'd1 - vi[2:0]);
    assign ibyte = 8'(u >> {sel, 3'b000});
    assign vbyte = vstr ? unit_char(r_e[0], vi[2:0]) : ibyte;

    always_comb begin
        case (r_e[3:1])
            3'd0:    u = r_e[0] ? 32'd9 : 32'd8;
            3'd1:    u = 32'd9;
            3'd2:    u = 32'd1;
            3'd3:    u = r_e[0] ? i_hum : i_temp;
            3'd4:    u = 32'd1;
            default: u = 32'd0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_cl    = r_cl;
        n_idl   = r_idl;
        n_get   = r_get;
        n_b     = r_b;
        n_rem   = r_rem;
        n_blen  = r_blen;
        n_olen  = r_olen;
        n_pos   = r_pos;
        n_bi    = r_bi;
        n_bli   = r_bli;
        n_e     = r_e;
        n_done  = 1'b0;
        n_ok    = r_ok;
        n_size  = r_size;
        n_raddr = 10'd0;
        fail    = 1'b0;
        put_en  = 1'b0;
        put_val = 8'h00;
        pat_en  = 1'b0;
        pat_addr = 8'h00;
        pat_val = 8'h00;
        eq      = 1'b0;
        lt      = 1'b0;
        hit     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_count > PktMax || i_count < 8'(MIN_PACKET)) begin
                        fail = 1'b1;
                    end else begin
                        n_state = S_HDR;
                        n_k     = 8'd0;
                    end
                end
            end
            S_HDR: begin
                pat_en   = 1'b1;
                pat_addr = r_k;
                pat_val  = (r_k > 8'd6 && r_k == 8'd7 + {3'd0, r_cl}) ? PDU_RESP : d;
                n_k      = r_k + 8'd1;
                n_raddr  = {2'd0, r_k} + 10'd1;
                if (r_k == 8'd0) begin
                    fail = (d != TAG_SEQ);
                end else if (r_k == 8'd1) begin
                    fail = ({1'b0, d} + 9'd2 != {1'b0, i_count});
                end else if (r_k < 8'd6) begin
                    fail = (d != head_byte(2'(r_k - 8'd2)));
                end else if (r_k == 8'd6) begin
                    n_cl = d[4:0];
                    fail = ({2'd0, i_count} < 10'(MIN_PACKET) + {2'd0, d})
                        || (d != {3'd0, i_cfg.len}) || (d > 8'(COMMUNITY_MAX));
                end else if (r_k < 8'd7 + {3'd0, r_cl}) begin
                    fail = (d != cbyte);
                end else if (rel == 8'd0) begin
                    n_get = (d == PDU_GET);
                    fail  = (d != PDU_GET) && (d != PDU_NEXT);
                end else if (rel == 8'd1) begin
                    fail = (10'd9 + {5'd0, r_cl} + {2'd0, d} != {2'd0, i_count}) || (d < 8'd14);
                end else if (rel == 8'd2) begin
                    fail = (d != TAG_INT);
                end else if (rel == 8'd3) begin
                    n_idl = d[2:0];
                    fail  = (d > 8'd4);
                end else if (rel < 8'd4 + {5'd0, r_idl}) begin
                    fail = 1'b0;
                end else if (t < 8'd7) begin
                    fail = (d != mid_byte(t[2:0]));
                end else begin
                    fail = (10'd19 + {5'd0, r_cl} + {7'd0, r_idl} + {2'd0, d}
                        != {2'd0, i_count});
                    n_rem   = d;
                    n_bli   = r_k;
                    n_pos   = r_k + 8'd1;
                    n_b     = {2'd0, r_k} + 10'd1;
                    n_k     = 8'd0;
                    n_state = S_BIND;
                end
            end
            S_BIND: begin
                n_k     = r_k + 8'd1;
                n_raddr = r_b + {2'd0, r_k} + 10'd1;
                case (r_k)
                    8'd0: fail = (r_rem < 8'd2) || (d != TAG_SEQ);
                    8'd1: begin
                        n_blen = d;
                        fail   = ({1'b0, r_rem} < {1'b0, d} + 9'd2);
                    end
                    8'd2: fail = (d != TAG_OID);
                    default: begin
                        n_olen  = d;
                        fail    = ({1'b0, d} + 9'd4 != {1'b0, r_blen});
                        n_k     = 8'd0;
                        n_raddr = r_b + {2'd0, r_blen};
                        n_state = S_BNULL;
                    end
                endcase
            end
            S_BNULL: begin
                if (r_k == 8'd0) begin
                    fail    = (d != TAG_NULL);
                    n_k     = 8'd1;
                    n_raddr = r_b + {2'd0, r_blen} + 10'd1;
                end else begin
                    fail    = (d != 8'h00);
                    n_k     = 8'd0;
                    n_state = S_BHDR;
                end
            end
            S_BHDR: begin
                put_en = 1'b1;
                n_k    = r_k + 8'd1;
                case (r_k)
                    8'd0: put_val = TAG_SEQ;
                    8'd1: begin
                        put_val = 8'h00;
                        n_bi    = r_pos;
                    end
                    default: begin
                        put_val = TAG_OID;
                        n_k     = 8'd0;
                        n_e     = 4'd0;
                        n_raddr = r_b + 10'd4;
                        n_state = S_LOOK;
                    end
                endcase
            end
            S_LOOK: begin
                if (r_k < {4'd0, nlen} && d == m) begin
                    n_k     = r_k + 8'd1;
                    n_raddr = r_b + 10'd5 + {2'd0, r_k};
                end else begin
                    eq  = (r_k >= {4'd0, nlen});
                    lt  = !eq && (d < m);
                    hit = r_get ? (r_olen == 8'(MIB_OID_LEN) && eq)
                                : (lt || (eq && r_olen < 8'(MIB_OID_LEN)));
                    n_k = 8'd0;
                    if (hit) begin
                        n_state = S_OID;
                    end else if (r_e == 4'(MIB_LAST)) begin
                        n_state = S_NFL;
                    end else begin
                        n_e     = r_e + 4'd1;
                        n_raddr = r_b + 10'd4;
                    end
                end
            end
            S_OID: begin
                put_en  = 1'b1;
                put_val = (r_k == 8'd0) ? 8'(MIB_OID_LEN) : mib_oid_byte(r_e, 4'(r_k - 8'd1));
                n_k     = r_k + 8'd1;
                if (r_k == 8'(MIB_OID_LEN)) begin
                    n_k     = 8'd0;
                    n_state = S_VAL;
                end
            end
            S_VAL: begin
                put_en = 1'b1;
                n_k    = r_k + 8'd1;
                if (r_k == 8'd0) begin
                    put_val = vstr ? TAG_OCTETS : TAG_INT;
                end else if (r_k == 8'd1) begin
                    put_val = vlen;
                end else begin
                    put_val = vbyte;
                end
                if (r_k == vlen + 8'd1) begin
                    n_state = S_BEND;
                end
            end
            S_NFL: begin
                put_en  = 1'b1;
                put_val = r_olen;
                n_k     = 8'd0;
                n_raddr = r_b + 10'd4;
                n_state = S_NFC;
            end
            S_NFC: begin
                put_en = 1'b1;
                if (r_k < r_olen) begin
                    put_val = d;
                    n_k     = r_k + 8'd1;
                    n_raddr = r_b + 10'd5 + {2'd0, r_k};
                end else begin
                    put_val = NO_SUCH_OBJ;
                    n_state = S_NFZ;
                end
            end
            S_NFZ: begin
                put_en  = 1'b1;
                put_val = 8'h00;
                n_state = S_BEND;
            end
            S_BEND: begin
                pat_en   = 1'b1;
                pat_addr = r_bi;
                pat_val  = r_pos - r_bi - 8'd1;
                n_b      = r_b + {2'd0, r_blen} + 10'd2;
                n_rem    = r_rem - r_blen - 8'd2;
                n_k      = 8'd0;
                n_raddr  = n_b;
                n_state  = (n_rem == 8'd0) ? S_P1 : S_BIND;
            end
            S_P1: begin
                pat_en   = 1'b1;
                pat_addr = 8'd1;
                pat_val  = r_pos - 8'd2;
                n_state  = S_P2;
            end
            S_P2: begin
                pat_en   = 1'b1;
                pat_addr = pdu;
                pat_val  = r_pos - pdu - 8'd1;
                n_state  = S_P3;
            end
            S_P3: begin
                pat_en   = 1'b1;
                pat_addr = r_bli;
                pat_val  = r_pos - r_bli - 8'd1;
                n_done   = 1'b1;
                n_ok     = 1'b1;
                n_size   = r_pos;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        ovf = put_en && (r_pos >= PktMax);
        if (put_en && !ovf) begin
            n_pos = r_pos + 8'd1;
        end
        if (fail || ovf) begin
            n_state = S_IDLE;
            n_done  = 1'b1;
            n_ok    = 1'b0;
            n_size  = 8'd0;
        end
    end

    assign n_rin     = (n_raddr < {2'd0, i_count}) && (n_raddr < 10'(PACKET_BYTES));
    assign o_rd_addr = n_raddr;
    assign o_wr_en   = (put_en && !ovf) || pat_en;
    assign o_wr_addr = pat_en ? pat_addr : r_pos;
    assign o_wr_data = pat_en ? pat_val : put_val;
    assign o_res     = '{done: r_done, ok: r_ok, size: r_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_k    <= n_k;
        r_rin  <= n_rin;
        r_cl   <= n_cl;
        r_idl  <= n_idl;
        r_get  <= n_get;
        r_b    <= n_b;
        r_rem  <= n_rem;
        r_blen <= n_blen;
        r_olen <= n_olen;
        r_pos  <= n_pos;
        r_bi   <= n_bi;
        r_bli  <= n_bli;
        r_e    <= n_e;
        r_ok   <= n_ok;
        r_size <= n_size;
    end
endmodule

@@ rtl/core/snmp_get_responder.sv @@
// Request byte, sensor update: the result is registered. Response byte: the buffer is read in
// the T_READ state, then the result is registered. Last request byte: header walk over the
// community and id, then per binding a parse, a MIB search over up to 12 entries comparing
// min(OID length, 11) bytes each, a write per response byte; then outer length patching.
// One transaction at a time; not ready while the sequencer runs.
// Synchronous active-low reset clears counters, sensor values, registers and the output valid;
// the packet buffers are not cleared.
module snmp_get_responder #(
    parameter int PACKET_BYTES = 129
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    snmp_in_if.sink     i_in,
    snmp_out_if.source  o_out,
    snmp_cfg_if.sink    i_cfg
);
    import snmp_pkg::*;

    localparam int AW = $clog2(PACKET_BYTES);
    localparam logic [7:0] PktMax  = 8'(PACKET_BYTES);
    localparam logic [7:0] PktOver = 8'(PACKET_BYTES + 1);

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_BUSY = 3'b010,
        T_READ = 3'b100
    } t_top_state;

    t_top_state r_state, n_state;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_rsize, n_rsize;
    logic [7:0]  r_rdpos, n_rdpos;
    logic [31:0] r_temp, n_temp;
    logic [31:0] r_hum, n_hum;
    t_cfg        r_cfg;
    logic        r_start, n_start;
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_out_status, n_out_status;
    logic [7:0]  r_out_len, n_out_len;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_last, n_out_last;

    logic        accept;
    logic        req_wr;
    logic [9:0]  eng_rd_addr;
    logic [7:0]  req_q, rsp_q;
    logic        eng_wr_en;
    logic [7:0]  eng_wr_addr, eng_wr_data;
    t_eng_res    eng_res;

    assign i_in.ready  = (r_state == T_IDLE) && (!r_out_valid || o_out.ready);
    assign accept      = i_in.valid && i_in.ready;
    assign req_wr      = accept && (i_in.action == ACT_REQ) && (r_count < PktMax);
    assign i_cfg.ready = 1'b1;

    snmp_mem #(.DEPTH(PACKET_BYTES)) u_req_mem (
        .i_clk     (i_clk),
        .i_wr_en   (req_wr),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_in.request_byte),
        .i_rd_addr (eng_rd_addr[AW-1:0]),
        .o_rd_data (req_q)
    );

    snmp_mem #(.DEPTH(PACKET_BYTES)) u_rsp_mem (
        .i_clk     (i_clk),
        .i_wr_en   (eng_wr_en),
        .i_wr_addr (eng_wr_addr[AW-1:0]),
        .i_wr_data (eng_wr_data),
        .i_rd_addr (r_rdpos[AW-1:0]),
        .o_rd_data (rsp_q)
    );

    snmp_engine #(.PACKET_BYTES(PACKET_BYTES)) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_count   (r_count),
        .i_cfg     (r_cfg),
        .i_temp    (r_temp),
        .i_hum     (r_hum),
        .o_rd_addr (eng_rd_addr),
        .i_rd_data (req_q),
        .o_wr_en   (eng_wr_en),
        .o_wr_addr (eng_wr_addr),
        .o_wr_data (eng_wr_data),
        .o_res     (eng_res)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rsize      = r_rsize;
        n_rdpos      = r_rdpos;
        n_temp       = r_temp;
        n_hum        = r_hum;
        n_start      = 1'b0;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_len    = r_out_len;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;

        case (r_state)
            T_IDLE: begin
                if (accept) begin
                    n_out_status = ST_ACCEPTED;
                    n_out_len    = 8'd0;
                    n_out_byte   = 8'd0;
                    n_out_last   = 1'b0;
                    case (i_in.action)
                        ACT_REQ: begin
                            n_count = (r_count < PktMax) ? r_count + 8'd1 : PktOver;
                            if (i_in.request_last) begin
                                n_start = 1'b1;
                                n_state = T_BUSY;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        ACT_READ: begin
                            if (r_rdpos < r_rsize) begin
                                n_state = T_READ;
                            end else begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_EMPTY;
                            end
                        end
                        ACT_SENSOR: begin
                            n_temp      = i_in.temperature;
                            n_hum       = i_in.humidity;
                            n_out_valid = 1'b1;
                        end
                        default: n_out_valid = 1'b1;
                    endcase
                end
            end
            T_BUSY: begin
                if (eng_res.done) begin
                    n_count      = 8'd0;
                    n_rdpos      = 8'd0;
                    n_rsize      = eng_res.ok ? eng_res.size : 8'd0;
                    n_out_valid  = 1'b1;
                    n_out_status = eng_res.ok ? ST_READY : ST_DROPPED;
                    n_out_len    = eng_res.ok ? eng_res.size : 8'd0;
                    n_out_byte   = 8'd0;
                    n_out_last   = 1'b0;
                    n_state      = T_IDLE;
                end
            end
            T_READ: begin
                n_out_valid  = 1'b1;
                n_out_status = ST_BYTE;
                n_out_len    = 8'd0;
                n_out_byte   = rsp_q;
                n_out_last   = (r_rdpos + 8'd1 == r_rsize);
                n_rdpos      = r_rdpos + 8'd1;
                n_state      = T_IDLE;
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_count     <= 8'd0;
            r_rsize     <= 8'd0;
            r_rdpos     <= 8'd0;
            r_temp      <= 32'd0;
            r_hum       <= 32'd0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg       <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rsize     <= n_rsize;
            r_rdpos     <= n_rdpos;
            r_temp      <= n_temp;
            r_hum       <= n_hum;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                case (i_cfg.reg_index)
                    REG_COMM_LEN:   r_cfg.len   <= i_cfg.wr_data[4:0];
                    REG_COMM_FIRST: r_cfg.first <= i_cfg.wr_data;
                    REG_COMM_LAST:  r_cfg.last  <= i_cfg.wr_data;
                    default:        r_cfg       <= r_cfg;
                endcase
            end
        end
        r_out_status <= n_out_status;
        r_out_len    <= n_out_len;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out_status;
    assign o_out.response_length = r_out_len;
    assign o_out.response_byte   = r_out_byte;
    assign o_out.response_last   = r_out_last;
endmodule

@@ rtl/core/snmp_chk.sv @@
// Port-level checker for the SNMP GET responder result channel, bound to the top level.
// Depends on snmp_pkg and the top-level ports.
module snmp_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [2:0] i_status,
    input logic [7:0] i_length,
    input logic [7:0] i_data,
    input logic       i_last
);
    import snmp_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_status) && $stable(i_length)
            && $stable(i_data) && $stable(i_last)))
        else $error("result changed while stalled");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((i_status == ST_READY) == (i_length != 8'd0)))
        else $error("length does not match status");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_last) |-> (i_status == ST_BYTE))
        else $error("last flag without response byte");

    a_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status != ST_BYTE) |-> (i_data == 8'd0))
        else $error("data byte outside response byte transaction");
endmodule

bind snmp_get_responder snmp_chk u_snmp_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_status (o_out.status),
    .i_length (o_out.response_length),
    .i_data   (o_out.response_byte),
    .i_last   (o_out.response_last)
);

@@ bench/snmp_get_responder_tb.sv @@
// Self-checking bench for snmp_get_responder: request packets, response reads, sensor updates.
// Depends on snmp_pkg and the channel interfaces in snmp_if.sv; holds its own SNMP agent model.
module snmp_get_responder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import snmp_pkg::*;

    localparam int PKT_MAX   = 129;
    localparam int CYCLE_CAP = 3000000;

    typedef struct {
        logic [2:0] status;
        logic [7:0] length;
        logic [7:0] data;
        logic       last;
    } t_reply;

    class agent_scoreboard;
        logic [7:0]  req_mem [PKT_MAX];
        logic [7:0]  rsp_mem [PKT_MAX];
        int unsigned req_cnt, rsp_size, rd_pos, pos;
        bit          ok;
        logic [31:0] temp_val, hum_val;
        logic [4:0]  comm_len;
        logic [63:0] comm_first, comm_last;
        t_reply      pending[$];
        int          mismatches, replies_seen, ready_seen, dropped_seen;

        function new();
            req_cnt = 0; rsp_size = 0; rd_pos = 0; temp_val = 0; hum_val = 0;
            comm_len = 0; comm_first = 0; comm_last = 0;
            mismatches = 0; replies_seen = 0; ready_seen = 0; dropped_seen = 0;
            foreach (req_mem[i]) req_mem[i] = 0;
            foreach (rsp_mem[i]) rsp_mem[i] = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] v);
            case (idx)
                REG_COMM_LEN:   comm_len = v[4:0];
                REG_COMM_FIRST: comm_first = v;
                REG_COMM_LAST:  comm_last = v;
                default: ;
            endcase
        endfunction

        function int unsigned pk(int unsigned i);
            return (i < req_cnt && i < PKT_MAX) ? req_mem[i] : 0;
        endfunction

        function void put(int unsigned v);
            if (!ok || pos + 1 > PKT_MAX) begin
                ok = 0;
                return;
            end
            rsp_mem[pos] = v[7:0];
            pos++;
        endfunction

        function int unsigned comm_byte(int unsigned k);
            logic [63:0] w;
            w = (k < 8) ? comm_first : comm_last;
            return (w >> (56 - 8 * (k % 8))) & 64'hff;
        endfunction

        function int unsigned oid_byte(int unsigned e, int unsigned k);
            logic [7:0] pre [9];
            pre = '{8'h2b, 8'h06, 8'h01, 8'h02, 8'h01, 8'h63, 8'h01, 8'h01, 8'h01};
            if (k < 9) return pre[k];
            if (k == 9) return e / 2 + 1;
            return e % 2 + 1;
        endfunction

        function void put_int(logic [31:0] u);
            int unsigned n;
            logic [31:0] mask, lo, ext;
            n = 4;
            for (int i = 1; i < 4; i++) begin
                mask = (32'd1 << (8 * i)) - 1;
                lo = u & mask;
                ext = lo[8 * i - 1] ? (lo | ~mask) : lo;
                if (ext == u) begin
                    n = i;
                    break;
                end
            end
            put(TAG_INT);
            put(n);
            for (int i = n; i > 0; i--) put((u >> (8 * (i - 1))) & 32'hff);
        endfunction

        function void put_value(int unsigned e);
            int unsigned col, row;
            string s;
            col = e / 2 + 1;
            row = e % 2 + 1;
            case (col)
                1: put_int(row == 1 ? 8 : 9);
                2: put_int(9);
                3: put_int(1);
                4: put_int(row == 1 ? temp_val : hum_val);
                5: put_int(1);
                default: begin
                    s = (row == 1) ? "x0.1 *C" : "x0.1 %RH";
                    put(TAG_OCTETS);
                    put(s.len());
                    for (int k = 0; k < s.len(); k++) put(s[k]);
                end
            endcase
        endfunction

        function int find_entry(int unsigned op, int unsigned at, int unsigned olen);
            int unsigned n, a, m;
            int cmp;
            for (int e = 0; e <= MIB_LAST; e++) begin
                n = olen < MIB_OID_LEN ? olen : MIB_OID_LEN;
                cmp = 0;
                for (int k = 0; k < n && cmp == 0; k++) begin
                    a = pk(at + k);
                    m = oid_byte(e, k);
                    if (a != m) cmp = a < m ? -1 : 1;
                end
                if (op == PDU_GET) begin
                    if (olen == MIB_OID_LEN && cmp == 0) return e;
                end else if (cmp < 0 || (cmp == 0 && olen < MIB_OID_LEN)) begin
                    return e;
                end
            end
            return -1;
        endfunction

        function int unsigned build_response();
            int unsigned len, cl, r, op, rl, idl, r2, bl, b, rem, bli, pdu;
            int unsigned blen, olen, bi;
            int e;
            len = req_cnt;
            if (len > PKT_MAX || len < MIN_PACKET) return 0;
            if (pk(0) != TAG_SEQ || pk(1) + 2 != len) return 0;
            for (int k = 0; k < 4; k++) if (pk(2 + k) != head_ref(k)) return 0;
            cl = pk(6);
            if (len < MIN_PACKET + cl) return 0;
            if (cl != comm_len || cl > COMMUNITY_MAX) return 0;
            for (int k = 0; k < cl; k++) if (pk(7 + k) != comm_byte(k)) return 0;
            r = 7 + cl;
            op = pk(r);
            if (op != PDU_GET && op != PDU_NEXT) return 0;
            rl = pk(r + 1);
            if (9 + cl + rl != len || rl < 14) return 0;
            if (pk(r + 2) != TAG_INT) return 0;
            idl = pk(r + 3);
            if (idl > 4) return 0;
            r2 = r + 4 + idl;
            for (int k = 0; k < 7; k++) if (pk(r2 + k) != mid_ref(k)) return 0;
            bl = pk(r2 + 7);
            if (19 + cl + idl + bl != len) return 0;
            pos = 0;
            ok = 1;
            for (int k = 0; k < 18 + cl + idl; k++) put(pk(k));
            if (!ok) return 0;
            rsp_mem[7 + cl] = PDU_RESP;
            pdu = 8 + cl;
            bli = pos;
            put(0);
            b = r2 + 8;
            rem = bl;
            do begin
                if (rem < 2 || pk(b) != TAG_SEQ) return 0;
                blen = pk(b + 1);
                if (rem < blen + 2 || pk(b + 2) != TAG_OID) return 0;
                olen = pk(b + 3);
                if (olen + 4 != blen) return 0;
                if (pk(b + blen) != TAG_NULL || pk(b + blen + 1) != 0) return 0;
                put(TAG_SEQ);
                bi = pos;
                put(0);
                put(TAG_OID);
                e = find_entry(op, b + 4, olen);
                if (e >= 0) begin
                    put(MIB_OID_LEN);
                    for (int k = 0; k < MIB_OID_LEN; k++) put(oid_byte(e, k));
                    put_value(e);
                end else begin
                    put(olen);
                    for (int k = 0; k < olen; k++) put(pk(b + 4 + k));
                    put(NO_SUCH_OBJ);
                    put(0);
                end
                if (!ok) return 0;
                rsp_mem[bi] = pos - bi - 1;
                b += blen + 2;
                rem -= blen + 2;
            end while (rem != 0);
            rsp_mem[1] = pos - 2;
            rsp_mem[pdu] = pos - pdu - 1;
            rsp_mem[bli] = pos - bli - 1;
            return pos;
        endfunction

        function int unsigned head_ref(int unsigned k);
            logic [7:0] h [4];
            h = '{8'h02, 8'h01, 8'h01, 8'h04};
            return h[k];
        endfunction

        function int unsigned mid_ref(int unsigned k);
            logic [7:0] m [7];
            m = '{8'h02, 8'h01, 8'h00, 8'h02, 8'h01, 8'h00, 8'h30};
            return m[k];
        endfunction

        function void note_item(logic [1:0] act, logic [7:0] data, logic last,
                                logic [31:0] temp, logic [31:0] hum);
            t_reply x;
            int unsigned n;
            x = '{status: ST_ACCEPTED, length: 0, data: 0, last: 0};
            if (act == ACT_REQ) begin
                if (req_cnt < PKT_MAX) begin
                    req_mem[req_cnt] = data;
                    req_cnt++;
                end else begin
                    req_cnt = PKT_MAX + 1;
                end
                if (last) begin
                    rsp_size = 0;
                    rd_pos = 0;
                    n = build_response();
                    req_cnt = 0;
                    if (n != 0) begin
                        rsp_size = n;
                        x.status = ST_READY;
                        x.length = n[7:0];
                        ready_seen++;
                    end else begin
                        x.status = ST_DROPPED;
                        dropped_seen++;
                    end
                end
            end else if (act == ACT_READ) begin
                if (rd_pos < rsp_size && rd_pos < PKT_MAX) begin
                    x.status = ST_BYTE;
                    x.data = rsp_mem[rd_pos];
                    x.last = (rd_pos + 1 == rsp_size);
                    rd_pos++;
                end else begin
                    x.status = ST_EMPTY;
                end
            end else if (act == ACT_SENSOR) begin
                temp_val = temp;
                hum_val = hum;
            end
            pending.push_back(x);
        endfunction

        function void check_result(logic [2:0] st, logic [7:0] len, logic [7:0] data,
                                   logic last);
            t_reply x;
            replies_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d length %0d byte %02h last %0d",
                             st, len, data, last);
                return;
            end
            x = pending.pop_front();
            if (st !== x.status || len !== x.length || data !== x.data || last !== x.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp st %0d len %0d byte %02h last %0d, got %0d %0d %02h %0d",
                             x.status, x.length, x.data, x.last, st, len, data, last);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    snmp_in_if  in_ch();
    snmp_out_if out_ch();
    snmp_cfg_if cfg_ch();

    snmp_get_responder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    agent_scoreboard sb;
    int   cycles;
    int   items_sent;
    bit   calm;
    bit   hold_req;
    logic [7:0] pkt_q[$];

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        sb = new();
        in_ch.valid = 0; in_ch.action = 0; in_ch.request_byte = 0; in_ch.request_last = 0;
        in_ch.temperature = 0; in_ch.humidity = 0;
        cfg_ch.valid = 0; cfg_ch.reg_index = 0; cfg_ch.wr_data = 0;
        out_ch.ready = 0;
        i_rst_n = 0;
        calm = 0;
        hold_req = 0;
        items_sent = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end
    initial cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            sb.note_item(in_ch.action, in_ch.request_byte, in_ch.request_last,
                         in_ch.temperature, in_ch.humidity);
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready)
            sb.write_reg(cfg_ch.reg_index, cfg_ch.wr_data);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.status, out_ch.response_length, out_ch.response_byte,
                            out_ch.response_last);
    end

    initial begin : result_sink
        int hold;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready = 0;
                for (hold = 0; hold < 400; hold++) @(negedge i_clk);
                hold_req = 0;
            end
            out_ch.ready = calm || ($urandom_range(0, 99) >= 12);
        end
    end

    task automatic send_item(logic [1:0] act, logic [7:0] data, logic last,
                             logic [31:0] temp, logic [31:0] hum);
        if (!calm && $urandom_range(0, 99) < 12) begin
            in_ch.valid = 0;
            @(negedge i_clk);
        end
        in_ch.valid = 1;
        in_ch.action = act;
        in_ch.request_byte = data;
        in_ch.request_last = last;
        in_ch.temperature = temp;
        in_ch.humidity = hum;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_q.size(); i++)
            send_item(ACT_REQ, pkt_q[i], i == pkt_q.size() - 1, $urandom, $urandom);
    endtask

    task automatic read_out(int extra);
        int n;
        n = sb.rsp_size + extra;
        for (int i = 0; i < n; i++) send_item(ACT_READ, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic drain_idle();
        in_ch.valid = 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [63:0] v);
        cfg_ch.valid = 1;
        cfg_ch.reg_index = idx;
        cfg_ch.wr_data = v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 0;
    endtask

    task automatic set_community(logic [4:0] len, logic [63:0] first, logic [63:0] last);
        drain_idle();
        write_cfg(REG_COMM_LEN, {59'd0, len});
        write_cfg(REG_COMM_FIRST, first);
        write_cfg(REG_COMM_LAST, last);
    endtask

    // kind: 0 exact entry, 1 entry with last byte moved (sometimes one byte longer), 2 prefix, 3 random, 4 empty
    task automatic add_binding(ref logic [7:0] bind_q[$], input int kind, input int e);
        logic [7:0] oid[$];
        int n;
        case (kind)
            0, 1: begin
                for (int k = 0; k < MIB_OID_LEN; k++) oid.push_back(sb.oid_byte(e, k));
                if (kind == 1) oid[MIB_OID_LEN - 1] = $urandom_range(0, 4);
                if (kind == 1 && $urandom_range(0, 1)) oid.push_back($urandom);
            end
            2: begin
                n = $urandom_range(1, 10);
                for (int k = 0; k < n; k++) oid.push_back(sb.oid_byte(e, k));
            end
            3: begin
                n = $urandom_range(1, 12);
                for (int k = 0; k < n; k++) oid.push_back($urandom);
            end
            default: ;
        endcase
        bind_q.push_back(TAG_SEQ);
        bind_q.push_back(oid.size() + 4);
        bind_q.push_back(TAG_OID);
        bind_q.push_back(oid.size());
        foreach (oid[k]) bind_q.push_back(oid[k]);
        bind_q.push_back(TAG_NULL);
        bind_q.push_back(8'h00);
    endtask

    task automatic make_packet(logic [7:0] op, int nbind, int kind);
        logic [7:0] bind_q[$];
        int cl, idl;
        cl = (sb.comm_len <= COMMUNITY_MAX) ? sb.comm_len : $urandom_range(0, COMMUNITY_MAX);
        idl = $urandom_range(0, 4);
        for (int i = 0; i < nbind; i++)
            add_binding(bind_q, (kind < 0) ? $urandom_range(0, 4) : kind,
                        $urandom_range(0, MIB_LAST));
        if (cl + idl < 4) idl = 4;
        pkt_q.delete();
        pkt_q.push_back(TAG_SEQ);
        pkt_q.push_back(17 + cl + idl + bind_q.size());
        pkt_q.push_back(8'h02); pkt_q.push_back(8'h01); pkt_q.push_back(8'h01);
        pkt_q.push_back(8'h04);
        pkt_q.push_back(cl);
        for (int k = 0; k < cl; k++) pkt_q.push_back(sb.comm_byte(k));
        pkt_q.push_back(op);
        pkt_q.push_back(10 + idl + bind_q.size());
        pkt_q.push_back(TAG_INT);
        pkt_q.push_back(idl);
        for (int k = 0; k < idl; k++) pkt_q.push_back($urandom);
        pkt_q.push_back(8'h02); pkt_q.push_back(8'h01); pkt_q.push_back(8'h00);
        pkt_q.push_back(8'h02); pkt_q.push_back(8'h01); pkt_q.push_back(8'h00);
        pkt_q.push_back(TAG_SEQ);
        pkt_q.push_back(bind_q.size());
        foreach (bind_q[k]) pkt_q.push_back(bind_q[k]);
    endtask

    task automatic random_session();
        int sel;
        make_packet($urandom_range(0, 1) ? PDU_GET : PDU_NEXT, $urandom_range(1, 4), -1);
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            pkt_q[$urandom_range(0, pkt_q.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
        end else if (sel < 14) begin
            void'(pkt_q.pop_back());
        end else if (sel < 17) begin
            pkt_q.push_back($urandom);
        end else if (sel < 19) begin
            while (pkt_q.size() < 135) pkt_q.push_back($urandom);
        end
        while (pkt_q.size() > 140) void'(pkt_q.pop_back());
        send_packet();
        if ($urandom_range(0, 9) == 0) read_out(-(sb.rsp_size / 2));
        else read_out($urandom_range(0, 2));
    endtask

    initial begin : stimulus
        @(posedge i_rst_n);
        @(negedge i_clk);
        // directed
        send_item(ACT_READ, 8'h00, 1'b0, 0, 0);
        send_item(2'd3, 8'hff, 1'b1, 32'hffffffff, 32'hffffffff);
        send_item(ACT_SENSOR, 0, 0, 32'h80000000, 32'h7fffffff);
        set_community(5'd6, "public\0\0", 64'h0);
        for (int e = 0; e <= MIB_LAST; e += 2) begin
            make_packet(PDU_GET, 2, 0);
            send_packet();
            read_out(1);
        end
        send_item(ACT_SENSOR, 0, 0, 32'hffffff80, 32'h00000080);
        make_packet(PDU_NEXT, 1, 4);
        send_packet();
        read_out(0);
        make_packet(PDU_GET, 0, 0);
        send_packet();
        make_packet(PDU_GET, 5, 0);
        send_packet();
        pkt_q.delete();
        repeat (140) pkt_q.push_back($urandom);
        send_packet();
        read_out(1);
        // random, across community settings
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_community(5'd0, 64'h0, 64'h0);
                1: set_community(5'd16, 64'hffffffffffffffff, $urandom * 64'd1 << 32 | $urandom);
                2: set_community(5'd31, {$urandom, $urandom}, {$urandom, $urandom});
                3: set_community($urandom_range(1, 15), {$urandom, $urandom}, {$urandom, $urandom});
                default: set_community(5'd8, {$urandom, $urandom}, 64'h0);
            endcase
            calm = (phase == 3);
            if (phase == 2) hold_req = 1;
            while (items_sent < 360 * (phase + 1)) begin
                if ($urandom_range(0, 99) < 75) begin
                    random_session();
                end else begin
                    send_item($urandom_range(0, 3), $urandom, $urandom_range(0, 7) == 0,
                              $urandom, $urandom);
                end
            end
            calm = 0;
        end
        drain_idle();
        repeat (200) @(negedge i_clk);
        $display("covered %0d items: %0d responses built, %0d packets dropped, %0d results",
                 items_sent, sb.ready_seen, sb.dropped_seen, sb.replies_seen);
        $display("community lengths 0, 6, 8, 16 and an over-long setting; %0d mismatches",
                 sb.mismatches + sb.pending.size());
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

@@ snmp_get_responder.f @@
rtl/core/snmp_pkg.sv
rtl/core/snmp_if.sv
rtl/core/snmp_mem.sv
rtl/core/snmp_engine.sv
rtl/core/snmp_get_responder.sv
rtl/core/snmp_chk.sv
bench/snmp_get_responder_tb.sv
